@@ sv/eds_pkg.sv @@
`default_nettype none
package eds_pkg;
   localparam int KIND_W = 2;
   localparam int TS_W = 32;
   localparam int RPM_W = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [RPM_W-1:0] RPM_MAX = '1;
   localparam logic [33:0] SPEED_NUM = 34'd6000000000;

   localparam logic [KIND_W-1:0] KIND_EDGE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_GEAR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TS_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic [RPM_W-1:0] rpm_x100;
      logic used_count_method;
      logic stopped;
   } rsp_type;
endpackage
`default_nettype wire

@@ sv/eds_stream_if.sv @@
`default_nettype none
interface eds_stream_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/eds_divider.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle. Denominator zero gives all ones.
module eds_divider #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [DEN_W:0] trial;

   // one restoring step
   always_comb begin
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (trial >= {1'b0, d_ff}) begin
         r_in = trial - {1'b0, d_ff};
         q_in = {q_ff[NUM_W-2:0], 1'b1};
      end else begin
         r_in = trial;
         q_in = {q_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= CNT_W'(NUM_W);
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = (d_ff == '0) ? '1 : q_ff;
endmodule
`default_nettype wire

@@ sv/eds_multiplier.sv @@
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle.
module eds_multiplier #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [A_W-1:0] a,
   input  wire logic [B_W-1:0] b,
   output logic done,
   output logic [A_W+B_W-1:0] prod
);
   localparam int CNT_W = $clog2(B_W + 1);
   logic [A_W+B_W-1:0] acc_ff, mcand_ff;
   logic [B_W-1:0] mplier_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= CNT_W'(B_W);
         acc_ff <= '0;
         mcand_ff <= (A_W+B_W)'(a);
         mplier_ff <= b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

@@ sv/encoder_dual_method_speed_unit.sv @@
`default_nettype none
// Encoder speed meter, one channel. Each request beat (edge, window tick or query)
// yields one response beat with speed in hundredths of rpm. The arithmetic runs
// on one 64-bit restoring divider and one 32x32 shift-add multiplier, used in
// turn. Every beat does two multiplies and one division for the edge speed and
// one multiply and one division for the count speed. A window tick that closes a
// window with pulses adds the window division and the pulses-per-rev multiply.
// The divider width is fixed at 64 bits, independent of TIME_WIDTH. One beat is
// worked at a time; the next request is taken once the response register is free.
module encoder_dual_method_speed_unit #(
   parameter int TIME_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   eds_stream_if.sink req,
   eds_stream_if.source rsp,
   input wire logic csr_we,
   input wire logic [eds_pkg::CSR_IDX_W-1:0] csr_idx,
   input wire logic [eds_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import eds_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_WDIV, S_TPRMUL, S_CNTMUL, S_CNTDIV, S_EMUL1, S_EMUL2, S_EDIV, S_OUT
   } state_type;

   localparam int DW = 64;
   localparam logic [TS_W-1:0] TPR_STOP = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   state_type state_ff;
   logic [9:0] gear_ff;
   logic [7:0] ppr_ff;
   logic [RPM_W-1:0] cutoff_ff, zero_ff;
   logic [TIME_WIDTH-1:0] last_ff, prior_ff, wstart_ff, now_ff;
   logic [COUNT_WIDTH-1:0] pcnt_ff;
   logic [TS_W-1:0] tpr_ff;
   logic [RPM_W-1:0] cspeed_ff;
   logic use_cnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic div_start, div_done, mul_start, mul_done;
   logic [DW-1:0] div_num, div_den, div_q;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] mul_hold_ff;
   logic [RPM_W-1:0] sat_q, espeed, chosen;
   logic [TIME_WIDTH-1:0] period;
   logic [TIME_WIDTH-1:0] window;
   req_type rq;
   logic go_ff;

   assign rq = req.payload;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign sat_q = (div_q > DW'(RPM_MAX)) ? RPM_MAX : div_q[RPM_W-1:0];
   assign period = last_ff - prior_ff;
   assign window = now_ff - wstart_ff;
   assign espeed = sat_q;
   assign chosen = use_cnt_ff ? cspeed_ff : espeed;

   eds_divider #(.NUM_W(DW), .DEN_W(DW)) u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_q));
   eds_multiplier #(.A_W(32), .B_W(32)) u_mul (
      .clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_p));

   // operand steering for the shared units
   always_comb begin
      div_num = DW'(SPEED_NUM);
      div_den = mul_hold_ff;
      mul_a = 32'(gear_ff);
      mul_b = tpr_ff;
      case (state_ff)
         S_WDIV: begin
            div_num = DW'(window);
            div_den = DW'(pcnt_ff);
         end
         S_TPRMUL: mul_a = 32'(ppr_ff);
         S_EMUL1: mul_b = 32'(ppr_ff);
         S_EMUL2: begin
            mul_a = mul_hold_ff[31:0];
            mul_b = 32'(period);
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      go_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         gear_ff <= 10'd80;
         ppr_ff <= 8'd2;
         cutoff_ff <= RPM_W'(1000);
         zero_ff <= RPM_W'(50);
         last_ff <= '0;
         prior_ff <= '0;
         pcnt_ff <= '0;
         wstart_ff <= '0;
         tpr_ff <= TPR_STOP;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_idx)
               CSR_GEAR: gear_ff <= csr_wdata[9:0];
               CSR_PPR: ppr_ff <= csr_wdata[7:0];
               CSR_CUTOFF: cutoff_ff <= csr_wdata;
               CSR_ZERO: zero_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               now_ff <= rq.time_us[TIME_WIDTH-1:0];
               go_ff <= 1'b1;
               if (rq.kind == KIND_EDGE) begin
                  prior_ff <= last_ff;
                  last_ff <= rq.time_us[TIME_WIDTH-1:0];
                  if (pcnt_ff != CNT_MAX) pcnt_ff <= pcnt_ff + 1'b1;
                  state_ff <= S_CNTMUL;
               end else if (rq.kind == KIND_TICK && pcnt_ff != '0) begin
                  state_ff <= S_WDIV;
               end else begin
                  if (rq.kind == KIND_TICK) tpr_ff <= TPR_STOP;
                  state_ff <= S_CNTMUL;
               end
            end
            S_WDIV: if (div_done) begin
               tpr_ff <= div_q[31:0];
               go_ff <= 1'b1;
               state_ff <= S_TPRMUL;
            end
            S_TPRMUL: if (mul_done) begin
               tpr_ff <= (mul_p[63:32] != '0) ? TPR_STOP : mul_p[31:0];
               pcnt_ff <= '0;
               wstart_ff <= now_ff;
               go_ff <= 1'b1;
               state_ff <= S_CNTMUL;
            end
            S_CNTMUL: if (mul_done) begin
               mul_hold_ff <= mul_p;
               go_ff <= 1'b1;
               state_ff <= S_CNTDIV;
            end
            S_CNTDIV: if (div_done) begin
               cspeed_ff <= sat_q;
               use_cnt_ff <= sat_q < cutoff_ff;
               go_ff <= 1'b1;
               state_ff <= S_EMUL1;
            end
            S_EMUL1: if (mul_done) begin
               mul_hold_ff <= mul_p;
               go_ff <= 1'b1;
               state_ff <= S_EMUL2;
            end
            S_EMUL2: if (mul_done) begin
               mul_hold_ff <= mul_p;
               go_ff <= 1'b1;
               state_ff <= S_EDIV;
            end
            S_EDIV: if (div_done) state_ff <= S_OUT;
            S_OUT: begin
               rsp_ff.used_count_method <= use_cnt_ff;
               rsp_ff.stopped <= chosen < zero_ff;
               rsp_ff.rpm_x100 <= (chosen < zero_ff) ? '0 : chosen;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // launch the unit owned by the new state as that state is entered
   assign div_start = go_ff && (state_ff == S_WDIV || state_ff == S_CNTDIV
                                || state_ff == S_EDIV);
   assign mul_start = go_ff && (state_ff == S_TPRMUL || state_ff == S_CNTMUL
                                || state_ff == S_EMUL1 || state_ff == S_EMUL2);
endmodule
`default_nettype wire

@@ sv/eds_checker.sv @@
`default_nettype none
module eds_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [23:0] rsp_rpm,
   input wire logic rsp_stopped
);
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped |-> rsp_rpm == '0) else $error("stopped with speed");
   a_no_take_while_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("took beat while full");
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second beat taken");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rpm))
      else $error("response dropped");
endmodule

bind encoder_dual_method_speed_unit eds_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_rpm(rsp.payload.rpm_x100),
   .rsp_stopped(rsp.payload.stopped));
`default_nettype wire

@@ tb/tb_encoder_dual_method_speed_unit.sv @@
`timescale 1ns / 100ps
module tb_encoder_dual_method_speed_unit;
   import eds_pkg::*;

   // Narrow pulse counter so that its saturation is reachable in a short run
   localparam int TIME_W = 32;
   localparam int COUNT_W = 8;
   // Longest beat (window tick with pulses) plus the longest response stall
   localparam int LATENCY = 400;
   localparam int STALL_LIMIT = 5000;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Predicts the speed report for every accepted request beat
   class speed_scoreboard;
      bit [9:0] gear;
      bit [7:0] ppr;
      bit [23:0] cutoff;
      bit [23:0] zero_thr;
      bit [TIME_W-1:0] last_edge;
      bit [TIME_W-1:0] prior_edge;
      bit [TIME_W-1:0] win_start;
      bit [31:0] rev_time;
      longint unsigned pulses;
      longint unsigned pulse_max;
      rsp_type speed_q[$];
      int errors;

      function new(int cw);
         pulse_max = (64'd1 << cw) - 1;
         gear = 10'd80;
         ppr = 8'd2;
         cutoff = 24'd1000;
         zero_thr = 24'd50;
         last_edge = '0;
         prior_edge = '0;
         win_start = '0;
         rev_time = '1;
         pulses = 0;
         errors = 0;
      endfunction

      function void set_regs(bit [23:0] g, bit [23:0] p, bit [23:0] c, bit [23:0] z);
         gear = g[9:0];
         ppr = p[7:0];
         cutoff = c;
         zero_thr = z;
      endfunction

      function longint unsigned rpm_of(longint unsigned divisor);
         longint unsigned q;
         if (divisor == 0) return RPM_MAX;
         q = 64'd6000000000 / divisor;
         return (q > RPM_MAX) ? RPM_MAX : q;
      endfunction

      function void note_request(req_type r);
         bit [TIME_W-1:0] now;
         bit [TIME_W-1:0] span;
         longint unsigned per_rev;
         longint unsigned edge_rpm;
         longint unsigned count_rpm;
         longint unsigned rpm;
         rsp_type exp_beat;
         now = r.time_us[TIME_W-1:0];
         if (r.kind == KIND_EDGE) begin
            prior_edge = last_edge;
            last_edge = now;
            if (pulses < pulse_max) pulses++;
         end else if (r.kind == KIND_TICK) begin
            if (pulses > 0) begin
               span = now - win_start;
               per_rev = (longint'(span) / pulses) * ppr;
               rev_time = (per_rev > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : per_rev[31:0];
               pulses = 0;
               win_start = now;
            end else begin
               rev_time = '1;
            end
         end
         span = last_edge - prior_edge;
         edge_rpm = rpm_of(longint'(gear) * ppr * span);
         count_rpm = rpm_of(longint'(gear) * rev_time);
         exp_beat.used_count_method = count_rpm < cutoff;
         rpm = exp_beat.used_count_method ? count_rpm : edge_rpm;
         exp_beat.stopped = rpm < zero_thr;
         exp_beat.rpm_x100 = exp_beat.stopped ? '0 : rpm[23:0];
         speed_q.push_back(exp_beat);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (speed_q.size() == 0) begin
            $display("%0t: unexpected response rpm=%0d", $time, got.rpm_x100);
            errors++;
            return;
         end
         want = speed_q.pop_front();
         if (got.rpm_x100 !== want.rpm_x100) begin
            $display("%0t: rpm_x100 expected %0d actual %0d", $time, want.rpm_x100,
                     got.rpm_x100);
            errors++;
         end
         if (got.used_count_method !== want.used_count_method) begin
            $display("%0t: used_count_method expected %0b actual %0b", $time,
                     want.used_count_method, got.used_count_method);
            errors++;
         end
         if (got.stopped !== want.stopped) begin
            $display("%0t: stopped expected %0b actual %0b", $time, want.stopped,
                     got.stopped);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit idle_on;
   int stall_cycles;
   speed_scoreboard sb;

   eds_stream_if #(.payload_type(req_type)) req_if ();
   eds_stream_if #(.payload_type(rsp_type)) rsp_if ();

   encoder_dual_method_speed_unit #(
      .TIME_WIDTH(TIME_W),
      .COUNT_WIDTH(COUNT_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr_we(csr_we),
      .csr_idx(csr_idx),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Beat monitors
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) sb.note_request(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Response backpressure in bursts
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic send_beat(logic [KIND_W-1:0] kind, logic [TS_W-1:0] ts);
      req_type r;
      r.kind = kind;
      r.time_us = ts;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Lets all results drain, then writes the four registers
   task automatic write_regs(bit [23:0] g, bit [23:0] p, bit [23:0] c, bit [23:0] z);
      req_if.valid <= 1'b0;
      while (sb.speed_q.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= CSR_GEAR;
      csr_wdata <= g;
      @(posedge clock);
      csr_idx <= CSR_PPR;
      csr_wdata <= p;
      @(posedge clock);
      csr_idx <= CSR_CUTOFF;
      csr_wdata <= c;
      @(posedge clock);
      csr_idx <= CSR_ZERO;
      csr_wdata <= z;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_regs(g, p, c, z);
   endtask

   // Realistic edge trains with ticks and queries mixed in, plus some noise
   task automatic run_traffic(int n);
      logic [TS_W-1:0] t;
      int unsigned step_max;
      int unsigned pick;
      t = $urandom;
      step_max = $urandom_range(1, 1 << $urandom_range(0, 18));
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            t = t + $urandom_range(0, step_max);
            send_beat(KIND_EDGE, t);
         end else if (pick < 80) begin
            t = t + $urandom_range(0, step_max);
            send_beat(KIND_TICK, t);
         end else if (pick < 90) begin
            send_beat(KIND_QUERY, $urandom);
         end else if (pick < 94) begin
            send_beat(KIND_UNUSED, $urandom);
         end else begin
            t = $urandom;
            send_beat(KIND_W'($urandom_range(0, 1)), t);
            step_max = $urandom_range(1, 1 << $urandom_range(0, 18));
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      idle_on = 1'b1;
      stall_cycles = 0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      sb = new(COUNT_W);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: timestamp extremes, wrap, zero period, empty window, all kinds
      send_beat(KIND_QUERY, 32'h0);
      send_beat(KIND_TICK, 32'h0);
      send_beat(KIND_EDGE, 32'h0);
      send_beat(KIND_EDGE, 32'd1000);
      send_beat(KIND_TICK, 32'd2000);
      send_beat(KIND_TICK, 32'd3000);
      send_beat(KIND_EDGE, 32'hFFFF_FFFF);
      send_beat(KIND_EDGE, 32'hFFFF_FFFF);
      send_beat(KIND_EDGE, 32'd5);
      send_beat(KIND_TICK, 32'hFFFF_FFFF);
      send_beat(KIND_UNUSED, 32'hAAAA_AAAA);
      send_beat(KIND_EDGE, 32'h5555_5555);
      send_beat(KIND_EDGE, 32'hAAAA_AAAA);
      send_beat(KIND_QUERY, 32'h5555_5555);
      send_beat(KIND_TICK, 32'h0);
      run_traffic(90);

      // Pulse counter saturation with unity scaling and zero thresholds
      write_regs(24'd1, 24'd1, 24'd0, 24'd0);
      for (int i = 0; i < 270; i++) send_beat(KIND_EDGE, 32'd100 + i * 7);
      send_beat(KIND_TICK, 32'd200000);
      send_beat(KIND_QUERY, 32'd0);

      write_regs(24'd1023, 24'd255, 24'hFF_FFFF, 24'hFF_FFFF);
      run_traffic(60);
      // Zero gear ratio and pulses per rev; upper data bits ignored
      write_regs(24'hFF_FC00, 24'hFF_FF00, 24'd2000, 24'd10);
      run_traffic(40);
      write_regs(24'($urandom), 24'($urandom), 24'($urandom_range(0, 100000)),
                 24'($urandom_range(0, 2000)));
      run_traffic(80);
      write_regs(24'd80, 24'd2, 24'd1000, 24'd50);
      run_traffic(40);

      // Final stretch at full throughput
      idle_on = 1'b0;
      write_regs(24'($urandom_range(1, 200)), 24'($urandom_range(1, 16)),
                 24'($urandom_range(0, 50000)), 24'($urandom_range(0, 500)));
      run_traffic(90);
      req_if.valid <= 1'b0;

      while (sb.speed_q.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.speed_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
